>>> sv/smtpcls_pkg.sv
// Package for the SMTP command line scanner: result type, command codes,
// command word table and byte constants. No dependencies.
package smtpcls_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int DATA_LENGTH_W   = 32;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;

  typedef enum logic [1:0] {
    KIND_AUTH  = 2'd0,
    KIND_BDAT  = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_XEXCH = 2'd3
  } kind_e;

  typedef struct packed {
    logic                     flush_here;
    logic                     enter_data;
    logic [1:0]               command_kind;
    logic [DATA_LENGTH_W-1:0] data_length;
  } result_t;

  function automatic logic [7:0] upper_of(input logic [7:0] b);
    if (b >= 8'h61 && b <= 8'h7A) begin
      return b - 8'd32;
    end
    return b;
  endfunction

  function automatic logic [2:0] word_len(input kind_e kind);
    return (kind == KIND_XEXCH) ? 3'd7 : 3'd4;
  endfunction

  // Upper-case letters of each command word, indexed by position.
  function automatic logic [7:0] word_char(input kind_e kind, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (kind)
      KIND_AUTH: begin
        case (pos)
          3'd0: c = "A";
          3'd1: c = "U";
          3'd2: c = "T";
          3'd3: c = "H";
          default: c = 8'h00;
        endcase
      end
      KIND_BDAT: begin
        case (pos)
          3'd0: c = "B";
          3'd1: c = "D";
          3'd2: c = "A";
          3'd3: c = "T";
          default: c = 8'h00;
        endcase
      end
      KIND_DATA: begin
        case (pos)
          3'd0: c = "D";
          3'd1: c = "A";
          3'd2: c = "T";
          3'd3: c = "A";
          default: c = 8'h00;
        endcase
      end
      KIND_XEXCH: begin
        case (pos)
          3'd0: c = "X";
          3'd1: c = "E";
          3'd2: c = "X";
          3'd3: c = "C";
          3'd4: c = "H";
          3'd5: c = "5";
          3'd6: c = "0";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> sv/smtpcls_if.sv
// Valid/ready channel interfaces of the SMTP command line scanner.
// Depends on smtpcls_pkg for the payload width.
interface smtpcls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface smtpcls_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   flush_here;
  logic                                   enter_data;
  logic [1:0]                             command_kind;
  logic [smtpcls_pkg::DATA_LENGTH_W-1:0]  data_length;

  modport source (output valid, output flush_here, output enter_data,
                  output command_kind, output data_length, input ready);
  modport sink   (input valid, input flush_here, input enter_data,
                  input command_kind, input data_length, output ready);
endinterface

>>> sv/smtpcls_core.sv
// Scanner state and per-byte next-state logic. Result for the presented
// byte is combinational; state moves when step_i is high.
// Depends on smtpcls_pkg.
module smtpcls_core #(
  parameter int LengthBits = smtpcls_pkg::LENGTH_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  output smtpcls_pkg::result_t res_o
);

  typedef enum logic [4:0] {
    ST_UNKNOWN = 5'b00001,
    ST_START   = 5'b00010,
    ST_MATCH   = 5'b00100,
    ST_LENGTH  = 5'b01000,
    ST_DONE    = 5'b10000
  } state_e;

  localparam logic [LengthBits+3:0] LenMax = {4'b0, {LengthBits{1'b1}}};

  state_e                  state_q, state_d;
  logic [2:0]              pos_q, pos_d;
  smtpcls_pkg::kind_e      kind_q, kind_d;
  logic [LengthBits-1:0]   len_q, len_d;

  logic [7:0]              upper_b;
  logic [LengthBits+3:0]   len_ext;
  logic [LengthBits+3:0]   len_next;
  logic [2:0]              pos_inc;
  logic                    is_digit;
  logic                    is_blank;

  assign upper_b  = smtpcls_pkg::upper_of(byte_i);
  assign is_digit = (byte_i >= smtpcls_pkg::CH_0) && (byte_i <= smtpcls_pkg::CH_9);
  assign is_blank = (byte_i == smtpcls_pkg::CH_SP) || (byte_i == smtpcls_pkg::CH_TAB);
  assign len_ext  = {4'b0, len_q};
  // len * 10 + digit as two shifts and two adds
  assign len_next = (len_ext << 3) + (len_ext << 1)
                  + {{(LengthBits){1'b0}}, byte_i[3:0] - smtpcls_pkg::CH_0[3:0]};
  assign pos_inc  = pos_q + 3'd1;

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    kind_d  = kind_q;
    len_d   = len_q;
    res_o   = '0;

    if (byte_i == smtpcls_pkg::CH_LF) begin
      res_o.flush_here = 1'b1;
      if (state_q == ST_DONE) begin
        res_o.enter_data  = 1'b1;
        res_o.data_length = smtpcls_pkg::DATA_LENGTH_W'(len_q);
        len_d             = '0;
      end
      state_d = ST_START;
    end else begin
      unique case (state_q)
        ST_START: begin
          state_d = ST_MATCH;
          pos_d   = 3'd1;
          case (upper_b)
            "A": kind_d = smtpcls_pkg::KIND_AUTH;
            "B": kind_d = smtpcls_pkg::KIND_BDAT;
            "D": kind_d = smtpcls_pkg::KIND_DATA;
            "X": kind_d = smtpcls_pkg::KIND_XEXCH;
            default: begin
              state_d = ST_UNKNOWN;
              pos_d   = pos_q;
            end
          endcase
        end
        ST_MATCH: begin
          if (pos_q < smtpcls_pkg::word_len(kind_q) &&
              upper_b == smtpcls_pkg::word_char(kind_q, pos_q)) begin
            pos_d = pos_inc;
            if (pos_inc >= smtpcls_pkg::word_len(kind_q)) begin
              pos_d   = 3'd0;
              state_d = ST_LENGTH;
            end
          end else begin
            pos_d   = 3'd0;
            state_d = ST_UNKNOWN;
          end
        end
        ST_LENGTH: begin
          if (is_blank) begin
            if (len_q != '0) begin
              state_d = ST_DONE;
            end
          end else if (is_digit) begin
            if (len_next < LenMax) begin
              len_d = len_next[LengthBits-1:0];
            end else begin
              len_d   = '0;
              state_d = ST_DONE;
            end
          end else begin
            len_d   = '0;
            state_d = ST_DONE;
          end
        end
        ST_UNKNOWN, ST_DONE: begin
          state_d = state_q;
        end
        default: state_d = ST_UNKNOWN;
      endcase
    end
    res_o.command_kind = kind_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_UNKNOWN;
      pos_q   <= 3'd0;
      kind_q  <= smtpcls_pkg::KIND_AUTH;
      len_q   <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      pos_q   <= pos_d;
      kind_q  <= kind_d;
      len_q   <= len_d;
    end
  end

endmodule

>>> sv/smtp_command_line_scanner_unit.sv
// Top level of the SMTP command line scanner: input register, scanner core,
// result register. Depends on smtpcls_pkg, smtpcls_if.sv and smtpcls_core.
//
//   channel  dir  payload                                              handshake
//   rx_i     in   rx_byte[7:0]                                         valid/ready
//   res_o    out  flush_here, enter_data, command_kind[1:0],           valid/ready
//                 data_length[31:0]
//
// One byte per cycle sustained while the result side is ready; an accepted byte
// passes through the input register and then the result register.
// The scanner state update sits between the input register and the result register.
// Reset puts the scanner in the waiting-for-line-feed state and empties both registers.
// A stalled result register holds; the input register still takes one more byte.
module smtp_command_line_scanner_unit #(
  parameter int LENGTH_BITS = smtpcls_pkg::LENGTH_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  smtpcls_in_if.sink           rx_i,
  smtpcls_out_if.source        res_o
);

  logic                 s1_valid_q;
  logic [7:0]           s1_byte_q;
  logic                 adv;
  logic                 out_valid_q;
  smtpcls_pkg::result_t out_q;
  smtpcls_pkg::result_t core_res;

  assign adv        = s1_valid_q && (!out_valid_q || res_o.ready);
  assign rx_i.ready = !s1_valid_q || adv;

  smtpcls_core #(
    .LengthBits(LENGTH_BITS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(adv),
    .byte_i(s1_byte_q),
    .res_o (core_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (rx_i.valid && rx_i.ready) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      s1_byte_q <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= core_res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.flush_here   = out_q.flush_here;
  assign res_o.enter_data   = out_q.enter_data;
  assign res_o.command_kind = out_q.command_kind;
  assign res_o.data_length  = out_q.data_length;

`ifndef SYNTHESIS
  a_enter_on_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.enter_data |-> res_o.flush_here)
    else $error("enter_data without line feed");

  a_len_only_on_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.enter_data |-> res_o.data_length == '0)
    else $error("data_length nonzero without enter_data");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> s1_valid_q && $stable(s1_byte_q))
    else $error("input register lost a pending item");

  a_no_adv_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_o.ready |-> !adv)
    else $error("core stepped while result stalled");
`endif

endmodule

>>> dv/smtp_command_line_scanner_unit_tb.sv
// Testbench for smtp_command_line_scanner_unit: a short table of bytes, then random
// command lines and noise, each result checked against a fixed table value or an in-bench scanner model.
// Depends on smtpcls_pkg and smtpcls_if.sv from the RTL.
`timescale 1ns / 1ps

module smtp_command_line_scanner_unit_tb;

  localparam int          LEN_BITS  = 32;
  localparam logic [63:0] LEN_LIMIT = (64'd1 << LEN_BITS) - 64'd1;
  localparam int          ITEM_GOAL = 1450;
  localparam int          NUM_ROWS  = 25;
  localparam logic [7:0]  CH_CR     = 8'h0D;
  localparam smtpcls_pkg::result_t RES_NONE = '0;

  typedef enum logic [2:0] {
    SCAN_WAIT   = 3'd0,
    SCAN_START  = 3'd1,
    SCAN_MATCH  = 3'd2,
    SCAN_LENGTH = 3'd3,
    SCAN_DONE   = 3'd4
  } scan_e;

  typedef struct {
    logic [7:0]           rx_byte;
    bit                   fixed;
    smtpcls_pkg::result_t res;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  smtpcls_in_if  rx_if ();
  smtpcls_out_if res_if ();

  smtp_command_line_scanner_unit #(
    .LENGTH_BITS(LEN_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .res_o (res_if)
  );

  // scanner model state
  scan_e               sc_state;
  logic [2:0]          sc_pos;
  smtpcls_pkg::kind_e  sc_kind;
  logic [LEN_BITS-1:0] sc_len;

  string                cmd_word [4] = '{"AUTH", "BDAT", "DATA", "XEXCH50"};
  smtpcls_pkg::result_t scan_results_q [$];
  logic [7:0]           line_bytes [$];
  stim_row_t            dir_rows [NUM_ROWS];
  int                   mismatch_cnt = 0;
  int                   sent_cnt = 0;
  int                   gap_pct = 0;
  int                   stall_pct = 0;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic smtpcls_pkg::result_t mk_res(input bit fl, input bit en,
                                                  input smtpcls_pkg::kind_e k,
                                                  input logic [31:0] len);
    smtpcls_pkg::result_t r;
    r.flush_here   = fl;
    r.enter_data   = en;
    r.command_kind = k;
    r.data_length  = len;
    return r;
  endfunction

  // Advances the scanner model by one byte and returns the result it gives.
  function automatic smtpcls_pkg::result_t scan_step(input logic [7:0] b);
    smtpcls_pkg::result_t r;
    logic [7:0]           up;
    logic [63:0]          nxt;
    r  = '0;
    up = fold_case(b);
    if (b == smtpcls_pkg::CH_LF) begin
      r.flush_here = 1'b1;
      if (sc_state == SCAN_DONE) begin
        r.enter_data  = 1'b1;
        r.data_length = sc_len;
        sc_len        = '0;
      end
      sc_state = SCAN_START;
    end else begin
      case (sc_state)
        SCAN_START: begin
          sc_state = SCAN_MATCH;
          case (up)
            "A": sc_kind = smtpcls_pkg::KIND_AUTH;
            "B": sc_kind = smtpcls_pkg::KIND_BDAT;
            "D": sc_kind = smtpcls_pkg::KIND_DATA;
            "X": sc_kind = smtpcls_pkg::KIND_XEXCH;
            default: sc_state = SCAN_WAIT;
          endcase
          if (sc_state == SCAN_MATCH) sc_pos = 3'd1;
        end
        SCAN_MATCH: begin
          if (int'(sc_pos) < cmd_word[sc_kind].len() && up == cmd_word[sc_kind][sc_pos]) begin
            if (int'(sc_pos) + 1 == cmd_word[sc_kind].len()) begin
              sc_pos   = 3'd0;
              sc_state = SCAN_LENGTH;
            end else begin
              sc_pos = sc_pos + 3'd1;
            end
          end else begin
            sc_pos   = 3'd0;
            sc_state = SCAN_WAIT;
          end
        end
        SCAN_LENGTH: begin
          if (b == smtpcls_pkg::CH_SP || b == smtpcls_pkg::CH_TAB) begin
            // blanks ahead of a non-zero length are skipped
            if (sc_len != '0) sc_state = SCAN_DONE;
          end else if (b >= smtpcls_pkg::CH_0 && b <= smtpcls_pkg::CH_9) begin
            nxt = 64'(sc_len) * 64'd10 + 64'(b - smtpcls_pkg::CH_0);
            if (nxt < LEN_LIMIT) begin
              sc_len = nxt[LEN_BITS-1:0];
            end else begin
              sc_len   = '0;
              sc_state = SCAN_DONE;
            end
          end else begin
            sc_len   = '0;
            sc_state = SCAN_DONE;
          end
        end
        default: ;
      endcase
    end
    r.command_kind = sc_kind;
    return r;
  endfunction

  // Entered at a falling edge; leaves at a falling edge with valid still high.
  task automatic send_item(input logic [7:0] b, input bit fixed,
                           input smtpcls_pkg::result_t fixed_res);
    int                   gap;
    smtpcls_pkg::result_t r;
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    r = scan_step(b);
    scan_results_q.push_back(fixed ? fixed_res : r);
    sent_cnt++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] random_case(input logic [7:0] c);
    if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) return c + 8'd32;
    return c;
  endfunction

  // any byte that ends a length: not a digit, blank or line feed
  function automatic logic [7:0] random_other();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == smtpcls_pkg::CH_LF || c == smtpcls_pkg::CH_SP || c == smtpcls_pkg::CH_TAB ||
           (c >= smtpcls_pkg::CH_0 && c <= smtpcls_pkg::CH_9));
    return c;
  endfunction

  task automatic build_command_line();
    int          k;
    logic [63:0] num;
    bit          has_num;
    string       digits;
    k       = $urandom_range(0, 3);
    has_num = 1'b1;
    for (int i = 0; i < cmd_word[k].len(); i++) line_bytes.push_back(random_case(cmd_word[k][i]));
    repeat ($urandom_range(0, 2)) begin
      line_bytes.push_back($urandom_range(0, 1) ? smtpcls_pkg::CH_SP : smtpcls_pkg::CH_TAB);
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) line_bytes.push_back(smtpcls_pkg::CH_0);
      if ($urandom_range(0, 1) == 1) line_bytes.push_back(smtpcls_pkg::CH_SP);
    end
    case ($urandom_range(0, 10))
      0, 1, 2, 3, 4: num = 64'($urandom_range(1, 999));
      5, 6:          num = 64'($urandom_range(1000, 99999999));
      7:             num = 64'hFFFF_FFFE;
      8:             num = 64'hFFFF_FFFF;
      9:             num = $urandom_range(0, 1) ? 64'($urandom) : 64'd98765432109876;
      default:       has_num = 1'b0;
    endcase
    if (has_num) begin
      digits = $sformatf("%0d", num);
      for (int i = 0; i < digits.len(); i++) line_bytes.push_back(digits[i]);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        line_bytes.push_back($urandom_range(0, 1) ? smtpcls_pkg::CH_SP : smtpcls_pkg::CH_TAB);
        repeat ($urandom_range(0, 3)) line_bytes.push_back(8'($urandom_range(0, 255)));
      end
      6, 7: line_bytes.push_back(random_other());
      default: ;  // line feed while still collecting
    endcase
    if ($urandom_range(0, 3) == 0) line_bytes.push_back(CH_CR);
    line_bytes.push_back(smtpcls_pkg::CH_LF);
  endtask

  task automatic build_broken_line();
    int k;
    k = $urandom_range(0, 3);
    for (int i = 0; i < $urandom_range(0, cmd_word[k].len() - 1); i++) begin
      line_bytes.push_back(random_case(cmd_word[k][i]));
    end
    line_bytes.push_back(random_case(8'($urandom_range(8'h41, 8'h5A))));
    repeat ($urandom_range(0, 4)) line_bytes.push_back(8'($urandom_range(0, 255)));
    line_bytes.push_back(smtpcls_pkg::CH_LF);
  endtask

  // receiver: random stalls, mostly short
  initial begin
    int stall;
    stall        = 0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        stall--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall        = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        res_if.ready <= 1'b0;
        stall--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    smtpcls_pkg::result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (scan_results_q.size() == 0) begin
        $error("result with no item pending");
        mismatch_cnt++;
      end else begin
        want = scan_results_q.pop_front();
        if (res_if.flush_here !== want.flush_here) begin
          $error("flush_here: expected %0d, got %0d", want.flush_here, res_if.flush_here);
          mismatch_cnt++;
        end
        if (res_if.enter_data !== want.enter_data) begin
          $error("enter_data: expected %0d, got %0d", want.enter_data, res_if.enter_data);
          mismatch_cnt++;
        end
        if (res_if.command_kind !== want.command_kind) begin
          $error("command_kind: expected %0d, got %0d", want.command_kind,
                 res_if.command_kind);
          mismatch_cnt++;
        end
        if (res_if.data_length !== want.data_length) begin
          $error("data_length: expected %0d, got %0d", want.data_length, res_if.data_length);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    int pick;
    int phase_no;
    bit drained;
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = 8'h00;
    sc_state      = SCAN_WAIT;
    sc_pos        = 3'd0;
    sc_kind       = smtpcls_pkg::KIND_AUTH;
    sc_len        = '0;
    phase_no      = 0;
    drained       = 1'b0;

    dir_rows = '{
      // ignored until first LF
      '{8'h00, 1'b1, mk_res(1'b0, 1'b0, smtpcls_pkg::KIND_AUTH, 32'd0)},
      '{smtpcls_pkg::CH_LF, 1'b1, mk_res(1'b1, 1'b0, smtpcls_pkg::KIND_AUTH, 32'd0)},
      '{"b",   1'b0, RES_NONE},                                 // first letter sets kind
      '{"q",   1'b0, RES_NONE},                                 // mismatch
      '{smtpcls_pkg::CH_LF, 1'b1, mk_res(1'b1, 1'b0, smtpcls_pkg::KIND_BDAT, 32'd0)},
      '{"d",   1'b0, RES_NONE},
      '{"A",   1'b0, RES_NONE},
      '{"t",   1'b0, RES_NONE},
      '{"a",   1'b0, RES_NONE},
      '{"9",   1'b0, RES_NONE},
      '{"!",   1'b0, RES_NONE},                                 // invalid byte clears length
      '{smtpcls_pkg::CH_LF, 1'b1, mk_res(1'b1, 1'b1, smtpcls_pkg::KIND_DATA, 32'd0)},
      '{"A",   1'b0, RES_NONE},
      '{"u",   1'b0, RES_NONE},
      '{"T",   1'b0, RES_NONE},
      '{"H",   1'b0, RES_NONE},
      '{"4",   1'b0, RES_NONE},
      // LF while collecting keeps 4
      '{smtpcls_pkg::CH_LF, 1'b1, mk_res(1'b1, 1'b0, smtpcls_pkg::KIND_AUTH, 32'd0)},
      '{"D",   1'b0, RES_NONE},
      '{"A",   1'b0, RES_NONE},
      '{"T",   1'b0, RES_NONE},
      '{"A",   1'b0, RES_NONE},
      '{"2",   1'b0, RES_NONE},
      '{smtpcls_pkg::CH_SP, 1'b0, RES_NONE},
      '{smtpcls_pkg::CH_LF, 1'b1, mk_res(1'b1, 1'b1, smtpcls_pkg::KIND_DATA, 32'd42)}
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni    <= 1'b1;
    gap_pct   = 30;
    stall_pct = 30;

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_item(dir_rows[i].rx_byte, dir_rows[i].fixed, dir_rows[i].res);
    end

    while (sent_cnt < NUM_ROWS + ITEM_GOAL) begin
      if (sent_cnt / 200 != phase_no) begin
        phase_no = sent_cnt / 200;
        if ($urandom_range(0, 3) == 0) begin
          gap_pct   = 0;
          stall_pct = 0;
        end else begin
          gap_pct   = $urandom_range(5, 50);
          stall_pct = $urandom_range(5, 50);
        end
      end
      if (!drained && sent_cnt >= 700) begin
        drained = 1'b1;
        rx_if.valid <= 1'b0;
        do @(negedge clk_i); while (scan_results_q.size() != 0);
      end
      line_bytes.delete();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        build_command_line();
      end else if (pick < 85) begin
        build_broken_line();
      end else begin
        repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) != 0) line_bytes.push_back(smtpcls_pkg::CH_LF);
      end
      foreach (line_bytes[i]) send_item(line_bytes[i], 1'b0, RES_NONE);
    end

    rx_if.valid <= 1'b0;
    do @(negedge clk_i); while (scan_results_q.size() != 0);
    repeat (8) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
